@@ rtl/core/t0wdt_pkg.sv @@
// ----------------------------------------------------------------------------
// t0wdt_pkg
// Shared types, codes and constants of the timer0 and watchdog core.
// ----------------------------------------------------------------------------
package t0wdt_pkg;

  // Field widths
  localparam int OP_BITS        = 2;
  localparam int CYC_BITS       = 8;
  localparam int TAKEN_BITS     = 2;
  localparam int TMR_BITS       = 8;
  localparam int PS_BITS        = 3;
  localparam int OPTION_BITS    = 8;
  localparam int WDT_BASE_BITS  = 20;

  // Watchdog counter width and compare width for the shifted limit
  localparam int WDT_COUNT_BITS = 32;
  localparam int WDT_LIMIT_BITS = WDT_BASE_BITS + (1 << PS_BITS) - 1;
  localparam int WDT_CMP_BITS   = (WDT_COUNT_BITS > WDT_LIMIT_BITS) ?
                                  WDT_COUNT_BITS : WDT_LIMIT_BITS;

  // Configuration port
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = WDT_BASE_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_OPTION   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WDT_EN   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WDT_BASE = 2'd2;

  localparam logic [OPTION_BITS-1:0]   OPTION_RESET   = 8'hFF;
  localparam logic [WDT_BASE_BITS-1:0] WDT_BASE_RESET = 20'd18000;

  // Option register bit positions
  localparam int OPT_T0CS = 5;
  localparam int OPT_T0SE = 4;
  localparam int OPT_PSA  = 3;

  // Operation codes
  localparam logic [OP_BITS-1:0] OP_STEP  = 2'd0;
  localparam logic [OP_BITS-1:0] OP_LOAD  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [OP_BITS-1:0]    op;
    logic [CYC_BITS-1:0]   cycle_low;
    logic [TAKEN_BITS-1:0] cycles_taken;
    logic                  pin_ra4;
    logic [TMR_BITS-1:0]   load_value;
  } in_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  typedef struct packed {
    logic [OPTION_BITS-1:0]   option_bits;
    logic                     wdt_enable;
    logic [WDT_BASE_BITS-1:0] wdt_base_cycles;
  } cfg_t;

endpackage

@@ rtl/core/t0wdt_in_if.sv @@
// ----------------------------------------------------------------------------
// t0wdt_in_if
// Input channel: one step item per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface t0wdt_in_if
  import t0wdt_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [OP_BITS-1:0]    op;
  logic [CYC_BITS-1:0]   cycle_low;
  logic [TAKEN_BITS-1:0] cycles_taken;
  logic                  pin_ra4;
  logic [TMR_BITS-1:0]   load_value;

  modport source (output valid, op, cycle_low, cycles_taken, pin_ra4, load_value,
                  input ready);
  modport sink   (input valid, op, cycle_low, cycles_taken, pin_ra4, load_value,
                  output ready);
endinterface

@@ rtl/core/t0wdt_out_if.sv @@
// ----------------------------------------------------------------------------
// t0wdt_out_if
// Result channel: timer value and event flags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface t0wdt_out_if
  import t0wdt_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [TMR_BITS-1:0] timer_value;
  logic                overflow;
  logic                wdt_timeout;

  modport source (output valid, timer_value, overflow, wdt_timeout, input ready);
  modport sink   (input valid, timer_value, overflow, wdt_timeout, output ready);
endinterface

@@ rtl/core/timer0_and_watchdog_core.sv @@
// ----------------------------------------------------------------------------
// timer0_and_watchdog_core
// 8-bit timer with prescaler and watchdog, stepped one item per beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one step item per beat: an instruction step, a timer load
//   or a watchdog clear. out_ch returns exactly one result per item, in
//   order: the timer value after the item, an overflow flag and a watchdog
//   timeout flag. The cfg_ port writes the option register, the watchdog
//   enable and the watchdog base period; write it only while no item is
//   in flight.
//   Flow: an accepted item is captured in the input register, and the
//   execute logic then loads its result into the result register; a stall
//   on out_ch keeps the item in the input register until the result drains.
//   Throughput: one item per cycle while out_ch is not stalled; the timer,
//   edge counter and watchdog update together in the single execute stage,
//   so each item sees the state left by the one before.
//   Reset clears the timer, the pin history, the edge counter and the
//   watchdog count, and loads option 0xFF, watchdog off, base 18000.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more item, then in_ch.ready drops until out_ch drains.
// ----------------------------------------------------------------------------
module timer0_and_watchdog_core
  import t0wdt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  t0wdt_in_if.sink                 in_ch,
  t0wdt_out_if.source              out_ch,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t   cfg;
  stage_t stg;
  logic   adv;

  t0wdt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  t0wdt_in_stage u_in (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .adv   (adv),
    .stg   (stg)
  );

  t0wdt_exec u_exec (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .stg    (stg),
    .adv    (adv),
    .out_ch (out_ch)
  );

`ifndef ASSERT_OFF
  // A wrap always lands the timer on zero
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.overflow |-> out_ch.timer_value == '0)
    else $error("overflow reported with nonzero timer value");

  // No timeout while the watchdog is disabled
  a_tmo_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.wdt_timeout |-> cfg.wdt_enable)
    else $error("watchdog timeout while disabled");

  // A held item is not dropped while the result register is stalled
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stg.valid && out_ch.valid && !out_ch.ready |=> stg.valid && out_ch.valid)
    else $error("item lost during output stall");
`endif

endmodule

@@ rtl/core/t0wdt_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// t0wdt_cfg_regs
// Option, watchdog enable and watchdog base period registers.
// ----------------------------------------------------------------------------
module t0wdt_cfg_regs
  import t0wdt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output cfg_t                     cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write; an index past the list is dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_OPTION:   cfg_nxt.option_bits     = cfg_data[OPTION_BITS-1:0];
        CFG_WDT_EN:   cfg_nxt.wdt_enable      = cfg_data[0];
        CFG_WDT_BASE: cfg_nxt.wdt_base_cycles = cfg_data[WDT_BASE_BITS-1:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.option_bits     <= OPTION_RESET;
      cfg_r.wdt_enable      <= 1'b0;
      cfg_r.wdt_base_cycles <= WDT_BASE_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/core/t0wdt_in_stage.sv @@
// ----------------------------------------------------------------------------
// t0wdt_in_stage
// Input register: captures one beat and holds it until the execute stage
// takes it.
// ----------------------------------------------------------------------------
module t0wdt_in_stage
  import t0wdt_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  t0wdt_in_if.sink       in_ch,
  input  logic           adv,
  output stage_t         stg
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     accept;

  // Accept while empty or while the held item moves on this cycle
  assign in_ch.ready = !valid_r || adv;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (adv) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.op           <= in_ch.op;
      item_r.cycle_low    <= in_ch.cycle_low;
      item_r.cycles_taken <= in_ch.cycles_taken;
      item_r.pin_ra4      <= in_ch.pin_ra4;
      item_r.load_value   <= in_ch.load_value;
    end
  end

  assign stg.valid = valid_r;
  assign stg.item  = item_r;

endmodule

@@ rtl/core/t0wdt_exec.sv @@
// ----------------------------------------------------------------------------
// t0wdt_exec
// Execute stage: updates timer, prescaler edge count and watchdog from the
// held item and loads the result register.
// ----------------------------------------------------------------------------
module t0wdt_exec
  import t0wdt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  stage_t    stg,
  output logic      adv,
  t0wdt_out_if.source out_ch
);

  logic [TMR_BITS-1:0]       tmr_r,  tmr_nxt;
  logic                      pin_r,  pin_nxt;
  logic [CYC_BITS-1:0]       edge_r, edge_nxt;
  logic [WDT_COUNT_BITS-1:0] wdt_r,  wdt_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic [TMR_BITS-1:0]       out_tmr_r;
  logic                      out_ovf_r;
  logic                      out_tmo_r;

  logic                      ext, falling, psa;
  logic [PS_BITS-1:0]        ps;
  logic [CYC_BITS-1:0]       rate_mask;
  logic                      pin_edge;
  logic                      tick;
  logic                      ovf;
  logic                      tmo;
  logic [WDT_COUNT_BITS:0]   wdt_sum;
  logic [WDT_COUNT_BITS-1:0] wdt_sat;
  logic [WDT_CMP_BITS-1:0]   limit;

  // Item moves when the result register is free or drains this cycle
  assign adv = stg.valid && (!out_valid_r || out_ch.ready);

  // Decode the option register
  assign ext     = cfg.option_bits[OPT_T0CS];
  assign falling = cfg.option_bits[OPT_T0SE];
  assign psa     = cfg.option_bits[OPT_PSA];
  assign ps      = cfg.option_bits[PS_BITS-1:0];

  // Prescaler mask: low ps+1 bits set
  always_comb begin
    for (int i = 0; i < CYC_BITS; i++) begin
      rate_mask[i] = (PS_BITS'(i) <= ps);
    end
  end

  assign pin_edge = falling ? (pin_r && !stg.item.pin_ra4)
                            : (!pin_r && stg.item.pin_ra4);

  // Saturating watchdog add and limit, shifted by the prescaler when PSA is set
  assign wdt_sum = {1'b0, wdt_r} + (WDT_COUNT_BITS+1)'(stg.item.cycles_taken);
  assign wdt_sat = wdt_sum[WDT_COUNT_BITS] ? '1 : wdt_sum[WDT_COUNT_BITS-1:0];
  assign limit   = psa ? (WDT_CMP_BITS'(cfg.wdt_base_cycles) << ps)
                       : WDT_CMP_BITS'(cfg.wdt_base_cycles);

  // Next state and result flags
  always_comb begin
    tmr_nxt  = tmr_r;
    pin_nxt  = pin_r;
    edge_nxt = edge_r;
    wdt_nxt  = wdt_r;
    tick     = 1'b0;
    tmo      = 1'b0;
    unique case (stg.item.op)
      OP_LOAD: begin
        tmr_nxt = stg.item.load_value;
      end
      OP_CLEAR: begin
        wdt_nxt = '0;
      end
      OP_STEP: begin
        if (ext) begin
          if (pin_edge) begin
            tick     = psa || ((edge_r & rate_mask) == '0);
            edge_nxt = CYC_BITS'(edge_r + CYC_BITS'(1));
          end
          pin_nxt = stg.item.pin_ra4;
        end else begin
          tick = psa || ((stg.item.cycle_low & rate_mask) == '0);
        end
        if (tick) begin
          tmr_nxt = TMR_BITS'(tmr_r + TMR_BITS'(1));
        end
        wdt_nxt = wdt_sat;
        if (cfg.wdt_enable && (WDT_CMP_BITS'(wdt_sat) >= limit)) begin
          wdt_nxt = '0;
          tmo     = 1'b1;
        end
      end
      default: begin
        tmr_nxt = tmr_r;
      end
    endcase
    ovf = tick && (tmr_r == '1);
  end

  // Hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmr_r       <= '0;
      pin_r       <= 1'b0;
      edge_r      <= '0;
      wdt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        tmr_r  <= tmr_nxt;
        pin_r  <= pin_nxt;
        edge_r <= edge_nxt;
        wdt_r  <= wdt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tmr_r <= tmr_nxt;
      out_ovf_r <= ovf;
      out_tmo_r <= tmo;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.timer_value = out_tmr_r;
  assign out_ch.overflow    = out_ovf_r;
  assign out_ch.wdt_timeout = out_tmo_r;

endmodule
